>>> rtl/ppi_pkg.sv
// ----------------------------------------------------------------------------
// ppi_pkg: shared definitions for the plane-plane intersection block
// Register indexes, reset values and the word carried by the divider pipeline.
// ----------------------------------------------------------------------------
package ppi_pkg;

    localparam int DIV_STEPS = 32;
    localparam int LANES     = 3;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t CFG_BASE_NORMAL_X    = 3'd0;
    localparam cfg_index_t CFG_BASE_NORMAL_Y    = 3'd1;
    localparam cfg_index_t CFG_BASE_NORMAL_Z    = 3'd2;
    localparam cfg_index_t CFG_BASE_OFFSET      = 3'd3;
    localparam cfg_index_t CFG_PARALLEL_EPSILON = 3'd4;

    localparam logic signed [15:0] RST_BASE_NORMAL_X    = 16'sd0;
    localparam logic signed [15:0] RST_BASE_NORMAL_Y    = 16'sd0;
    localparam logic signed [15:0] RST_BASE_NORMAL_Z    = 16'sd16384;
    localparam logic signed [31:0] RST_BASE_OFFSET      = 32'sd0;
    localparam logic [31:0]        RST_PARALLEL_EPSILON = 32'd26844;

    typedef struct packed {
        logic [LANES-1:0][63:0] rem;
        logic [LANES-1:0][31:0] mlo;
        logic [LANES-1:0][31:0] quo;
        logic [LANES-1:0]       neg;
        logic [LANES-1:0]       ovf;
        logic [63:0]            det;
        logic                   zero;
        logic [LANES-1:0][32:0] dir;
    } div_word_t;

endpackage

>>> rtl/plane_plane_intersection.sv
// ----------------------------------------------------------------------------
// plane_plane_intersection: line where a configured base plane meets a plane
// Fixed-point cross product, determinant test and origin solve per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Write the base plane normal, offset and epsilon through the cfg channel
//   (index, data; cfg_ready is always high) while no word is in flight.
//   Each input word carries a second plane; one result word comes back for
//   each, in order, on the out channel (valid/ready).
//   Path from acceptance to out_valid: 6 arithmetic stages, 32 divider
//   stages, 1 output register.
//   Throughput: one word per cycle while out_ready is high; the 32-stage
//   quotient pipeline, one bit per stage, sets the depth.
//   Stall: when out_ready is low the result holds; upstream stages keep
//   filling empty slots, and in_ready drops only once every stage is full.
//   Reset: all stage valid bits clear, cfg registers take their reset values
//   (normal 0,0,1.0, offset 0, epsilon about 1e-4).
//   Parallel or degenerate planes give intersects low and zero vectors.
// ----------------------------------------------------------------------------
module plane_plane_intersection
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  ppi_pkg::cfg_index_t cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  other_normal_x,
    input  logic signed [15:0]  other_normal_y,
    input  logic signed [15:0]  other_normal_z,
    input  logic signed [31:0]  other_offset,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                intersects,
    output logic signed [31:0]  origin_x,
    output logic signed [31:0]  origin_y,
    output logic signed [31:0]  origin_z,
    output logic signed [31:0]  direction_x,
    output logic signed [31:0]  direction_y,
    output logic signed [31:0]  direction_z
);

    localparam int L = ppi_pkg::LANES;

    logic signed [15:0] base_nx_reg, base_ny_reg, base_nz_reg;
    logic signed [31:0] base_offset_reg;
    logic [31:0]        epsilon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_nx_reg     <= ppi_pkg::RST_BASE_NORMAL_X;
            base_ny_reg     <= ppi_pkg::RST_BASE_NORMAL_Y;
            base_nz_reg     <= ppi_pkg::RST_BASE_NORMAL_Z;
            base_offset_reg <= ppi_pkg::RST_BASE_OFFSET;
            epsilon_reg     <= ppi_pkg::RST_PARALLEL_EPSILON;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ppi_pkg::CFG_BASE_NORMAL_X:    base_nx_reg     <= cfg_data[15:0];
                ppi_pkg::CFG_BASE_NORMAL_Y:    base_ny_reg     <= cfg_data[15:0];
                ppi_pkg::CFG_BASE_NORMAL_Z:    base_nz_reg     <= cfg_data[15:0];
                ppi_pkg::CFG_BASE_OFFSET:      base_offset_reg <= cfg_data;
                ppi_pkg::CFG_PARALLEL_EPSILON: epsilon_reg     <= cfg_data;
                default:                       ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic signed [15:0] a [L];
    logic signed [15:0] b [L];

    always_comb
    begin
        a[0] = base_nx_reg;
        a[1] = base_ny_reg;
        a[2] = base_nz_reg;
        b[0] = other_normal_x;
        b[1] = other_normal_y;
        b[2] = other_normal_z;
    end

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, vo_reg;
    logic en1, en2, en3, en4, en5, en6, eno;
    logic div_in_ready, div_out_valid;
    ppi_pkg::div_word_t div_out_word;

    // stage 1: cross product and dot products
    logic signed [31:0] ab [L][L];
    logic signed [31:0] aa [L];
    logic signed [31:0] bb [L];
    logic signed [32:0] c_next [L];
    logic [31:0]        n00_next, n11_next;
    logic signed [32:0] n01_next;

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            aa[i] = a[i] * a[i];
            bb[i] = b[i] * b[i];
            for (int j = 0; j < L; j++)
            begin
                ab[i][j] = a[i] * b[j];
            end
        end
        c_next[0] = {ab[1][2][31], ab[1][2]} - {ab[2][1][31], ab[2][1]};
        c_next[1] = {ab[2][0][31], ab[2][0]} - {ab[0][2][31], ab[0][2]};
        c_next[2] = {ab[0][1][31], ab[0][1]} - {ab[1][0][31], ab[1][0]};
        n00_next  = aa[0] + aa[1] + aa[2];
        n11_next  = bb[0] + bb[1] + bb[2];
        n01_next  = {ab[0][0][31], ab[0][0]} + {ab[1][1][31], ab[1][1]}
                  + {ab[2][2][31], ab[2][2]};
    end

    logic signed [32:0] s1_c_reg [L];
    logic signed [15:0] s1_b_reg [L];
    logic [31:0]        s1_n00_reg, s1_n11_reg;
    logic signed [32:0] s1_n01_reg;
    logic signed [31:0] s1_d2_reg;

    // stage 2: squares and offset products
    logic [63:0]        sq_next [L];
    logic signed [64:0] pa_next, pb_next, pc_next, pd_next;

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            sq_next[i] = s1_c_reg[i] * s1_c_reg[i];
        end
        pa_next = $signed({1'b0, s1_n11_reg}) * base_offset_reg;
        pb_next = s1_n01_reg * s1_d2_reg;
        pc_next = $signed({1'b0, s1_n00_reg}) * s1_d2_reg;
        pd_next = s1_n01_reg * base_offset_reg;
    end

    logic [63:0]        s2_sq_reg [L];
    logic signed [64:0] s2_pa_reg, s2_pb_reg, s2_pc_reg, s2_pd_reg;
    logic signed [32:0] s2_c_reg [L];
    logic signed [15:0] s2_b_reg [L];

    // stage 3: |c|^2 and solve coefficients
    logic [63:0]        csq_next;
    logic signed [65:0] ca_next, cb_next;

    always_comb
    begin
        csq_next = s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
        ca_next  = s2_pa_reg - s2_pb_reg;
        cb_next  = s2_pc_reg - s2_pd_reg;
    end

    logic [63:0]        s3_csq_reg;
    logic signed [65:0] s3_ca_reg, s3_cb_reg;
    logic signed [32:0] s3_c_reg [L];
    logic signed [15:0] s3_b_reg [L];

    // stage 4: numerator products and threshold test
    logic signed [81:0] na_next [L];
    logic signed [81:0] nb_next [L];
    logic               zero_next;

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            na_next[i] = s3_ca_reg * a[i];
            nb_next[i] = s3_cb_reg * s3_b_reg[i];
        end
        zero_next = (s3_csq_reg < {4'd0, epsilon_reg, 28'd0}) || (s3_csq_reg == 64'd0);
    end

    logic signed [81:0] s4_na_reg [L];
    logic signed [81:0] s4_nb_reg [L];
    logic               s4_zero_reg;
    logic [63:0]        s4_csq_reg;
    logic signed [32:0] s4_c_reg [L];

    // stage 5: numerators
    logic signed [82:0] num_next [L];

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            num_next[i] = s4_na_reg[i] + s4_nb_reg[i];
        end
    end

    logic signed [82:0] s5_num_reg [L];
    logic               s5_zero_reg;
    logic [63:0]        s5_csq_reg;
    logic signed [32:0] s5_c_reg [L];

    // stage 6: magnitude, scale by 2^14, overflow check
    ppi_pkg::div_word_t dw_next;
    ppi_pkg::div_word_t s6_dw_reg;

    always_comb
    begin
        logic [82:0] mag;
        logic [95:0] m;
        dw_next      = '0;
        dw_next.det  = s5_csq_reg;
        dw_next.zero = s5_zero_reg;
        for (int i = 0; i < L; i++)
        begin
            mag = s5_num_reg[i][82] ? 83'(-s5_num_reg[i]) : 83'(s5_num_reg[i]);
            m   = {mag[81:0], 14'd0};
            dw_next.neg[i] = s5_num_reg[i][82];
            dw_next.rem[i] = m[95:32];
            dw_next.mlo[i] = m[31:0];
            dw_next.ovf[i] = (m[95:32] >= s5_csq_reg);
            dw_next.dir[i] = s5_c_reg[i];
        end
    end

    assign eno = !vo_reg || out_ready;
    assign en6 = !v6_reg || div_in_ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
            if (eno) vo_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_c_reg   <= c_next;
            s1_b_reg   <= b;
            s1_n00_reg <= n00_next;
            s1_n11_reg <= n11_next;
            s1_n01_reg <= n01_next;
            s1_d2_reg  <= other_offset;
        end
        if (en2)
        begin
            s2_sq_reg <= sq_next;
            s2_pa_reg <= pa_next;
            s2_pb_reg <= pb_next;
            s2_pc_reg <= pc_next;
            s2_pd_reg <= pd_next;
            s2_c_reg  <= s1_c_reg;
            s2_b_reg  <= s1_b_reg;
        end
        if (en3)
        begin
            s3_csq_reg <= csq_next;
            s3_ca_reg  <= ca_next;
            s3_cb_reg  <= cb_next;
            s3_c_reg   <= s2_c_reg;
            s3_b_reg   <= s2_b_reg;
        end
        if (en4)
        begin
            s4_na_reg   <= na_next;
            s4_nb_reg   <= nb_next;
            s4_zero_reg <= zero_next;
            s4_csq_reg  <= s3_csq_reg;
            s4_c_reg    <= s3_c_reg;
        end
        if (en5)
        begin
            s5_num_reg  <= num_next;
            s5_zero_reg <= s4_zero_reg;
            s5_csq_reg  <= s4_csq_reg;
            s5_c_reg    <= s4_c_reg;
        end
        if (en6)
        begin
            s6_dw_reg <= dw_next;
        end
    end

    ppi_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .in_ready  (div_in_ready),
        .in_word   (s6_dw_reg),
        .out_valid (div_out_valid),
        .out_ready (eno),
        .out_word  (div_out_word)
    );

    // saturate and drop zero cases
    logic [31:0] org_next [L];
    logic [31:0] dir_next [L];
    logic [31:0] org_reg  [L];
    logic [31:0] dir_reg  [L];
    logic        hit_reg;

    always_comb
    begin
        logic [31:0] q;
        logic [32:0] d;
        for (int i = 0; i < L; i++)
        begin
            q = div_out_word.quo[i];
            d = div_out_word.dir[i];
            if (div_out_word.zero)
            begin
                org_next[i] = 32'd0;
                dir_next[i] = 32'd0;
            end
            else
            begin
                if (!div_out_word.neg[i])
                begin
                    org_next[i] = (div_out_word.ovf[i] || q[31]) ? 32'h7FFF_FFFF : q;
                end
                else
                begin
                    org_next[i] = (div_out_word.ovf[i] || q > 32'h8000_0000)
                                ? 32'h8000_0000 : 32'(-q);
                end
                if (d[32] != d[31])
                begin
                    dir_next[i] = d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                else
                begin
                    dir_next[i] = d[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eno)
        begin
            org_reg <= org_next;
            dir_reg <= dir_next;
            hit_reg <= !div_out_word.zero;
        end
    end

    assign out_valid   = vo_reg;
    assign intersects  = hit_reg;
    assign origin_x    = org_reg[0];
    assign origin_y    = org_reg[1];
    assign origin_z    = org_reg[2];
    assign direction_x = dir_reg[0];
    assign direction_y = dir_reg[1];
    assign direction_z = dir_reg[2];

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !intersects |->
            origin_x == 0 && origin_y == 0 && origin_z == 0 &&
            direction_x == 0 && direction_y == 0 && direction_z == 0)
        else $error("miss word carries nonzero vectors");

    a_hit_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && intersects |->
            direction_x != 0 || direction_y != 0 || direction_z != 0)
        else $error("hit word with zero direction");

    a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without output stall");

endmodule

>>> rtl/ppi_divider.sv
// ----------------------------------------------------------------------------
// ppi_divider: pipelined restoring divider, three lanes over a shared divisor
// One quotient bit per stage for each lane; bubbles collapse on a stall.
// ----------------------------------------------------------------------------
module ppi_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ppi_pkg::div_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output ppi_pkg::div_word_t  out_word
);

    ppi_pkg::div_word_t             stg_reg  [ppi_pkg::DIV_STEPS];
    ppi_pkg::div_word_t             stg_next [ppi_pkg::DIV_STEPS];
    logic [ppi_pkg::DIV_STEPS-1:0]  vld_reg;
    logic [ppi_pkg::DIV_STEPS-1:0]  en;

    always_comb
    begin
        en[ppi_pkg::DIV_STEPS-1] = !vld_reg[ppi_pkg::DIV_STEPS-1] || out_ready;
        for (int k = ppi_pkg::DIV_STEPS-2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        ppi_pkg::div_word_t src;
        logic [64:0] r2;
        logic [64:0] diff;
        logic        ge;
        for (int k = 0; k < ppi_pkg::DIV_STEPS; k++)
        begin
            src = (k == 0) ? in_word : stg_reg[k-1];
            stg_next[k] = src;
            for (int l = 0; l < ppi_pkg::LANES; l++)
            begin
                r2   = {src.rem[l], src.mlo[l][31]};
                diff = r2 - {1'b0, src.det};
                ge   = (r2 >= {1'b0, src.det});
                stg_next[k].rem[l] = ge ? diff[63:0] : r2[63:0];
                stg_next[k].mlo[l] = {src.mlo[l][30:0], 1'b0};
                stg_next[k].quo[l] = {src.quo[l][30:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < ppi_pkg::DIV_STEPS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= (k == 0) ? in_valid : vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ppi_pkg::DIV_STEPS; k++)
        begin
            if (en[k])
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[ppi_pkg::DIV_STEPS-1];
    assign out_word  = stg_reg[ppi_pkg::DIV_STEPS-1];

endmodule
